>>> rtl/ftam_pkg.sv
`default_nettype none
package ftam_pkg;

    localparam int unsigned SampleWidth = 32;
    localparam int unsigned MantWidth   = 24;
    localparam int unsigned ExpWidth    = 8;
    localparam int unsigned ProdWidth   = 47;
    localparam int unsigned ShiftWidth  = 10;
    localparam int unsigned PcmWidth    = 24;
    localparam logic [ExpWidth-1:0] ExpBias = 8'd127;
    localparam logic [7:0] LabelByte = 8'h40;

    typedef struct packed {
        logic                 sign;
        logic                 nan;
        logic                 inf;
        logic                 zero;
        logic [ExpWidth-1:0]  expo;
        logic [MantWidth-1:0] mant;
        logic                 last;
    } ftam_unp_t;

    typedef struct packed {
        logic                         sign;
        logic                         nan;
        logic                         inf;
        logic                         zero;
        logic signed [ShiftWidth-1:0] shamt;
        logic [MantWidth-1:0]         q;
        logic                         last;
    } ftam_flt_t;

endpackage
`default_nettype wire

>>> rtl/ftam_unpack.sv
`default_nettype none
module ftam_unpack
    import ftam_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [SampleWidth-1:0] s_tdata,
    input  wire logic                   s_tlast,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output ftam_unp_t                   out_data
);

    logic      valid_reg;
    ftam_unp_t data_reg;
    ftam_unp_t data_next;
    logic      exp_ones;
    logic      exp_zero;
    logic      frac_zero;

    assign s_tready = !valid_reg || out_ready;

    always_comb begin
        exp_ones  = &s_tdata[30:23];
        exp_zero  = ~|s_tdata[30:23];
        frac_zero = ~|s_tdata[22:0];
        data_next.sign = s_tdata[31];
        data_next.nan  = exp_ones && !frac_zero;
        data_next.inf  = exp_ones && frac_zero;
        data_next.zero = exp_zero;
        data_next.expo = s_tdata[30:23];
        data_next.mant = {1'b1, s_tdata[22:0]};
        data_next.last = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> rtl/ftam_scale.sv
`default_nettype none
module ftam_scale
    import ftam_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire ftam_unp_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output ftam_flt_t      out_data
);

    typedef struct packed {
        logic                 sign;
        logic                 nan;
        logic                 inf;
        logic                 zero;
        logic [ExpWidth-1:0]  expo;
        logic [ProdWidth-1:0] prod;
        logic                 last;
    } ftam_prod_t;

    logic       p_valid_reg;
    ftam_prod_t p_reg;
    ftam_prod_t p_next;
    logic       p_ready;

    logic       f_valid_reg;
    ftam_flt_t  f_reg;
    ftam_flt_t  f_next;

    logic [MantWidth-1:0] q0;
    logic                 guard;
    logic                 sticky;
    logic                 up;
    logic [MantWidth:0]   qsum;
    logic signed [ShiftWidth-1:0] kval;

    assign p_ready  = !f_valid_reg || out_ready;
    assign in_ready = !p_valid_reg || p_ready;

    // mant * (2^23 - 1), exact
    always_comb begin
        p_next.sign = in_data.sign;
        p_next.nan  = in_data.nan;
        p_next.inf  = in_data.inf;
        p_next.zero = in_data.zero;
        p_next.expo = in_data.expo;
        p_next.prod = {in_data.mant, 23'd0} - {23'd0, in_data.mant};
        p_next.last = in_data.last;
    end

    // round product to single precision, ties to even
    always_comb begin
        if (p_reg.prod[46]) begin
            q0     = p_reg.prod[46:23];
            guard  = p_reg.prod[22];
            sticky = |p_reg.prod[21:0];
        end else begin
            q0     = p_reg.prod[45:22];
            guard  = p_reg.prod[21];
            sticky = |p_reg.prod[20:0];
        end
        up   = guard && (sticky || q0[0]);
        qsum = {1'b0, q0} + {{MantWidth{1'b0}}, up};
        kval = $signed({2'b00, p_reg.expo}) - $signed({2'b00, ExpBias})
             - $signed({{(ShiftWidth-1){1'b0}}, !p_reg.prod[46]})
             + $signed({{(ShiftWidth-1){1'b0}}, qsum[MantWidth]});
        f_next.sign  = p_reg.sign;
        f_next.nan   = p_reg.nan;
        f_next.inf   = p_reg.inf;
        f_next.zero  = p_reg.zero;
        f_next.shamt = kval;
        f_next.q     = qsum[MantWidth] ? {1'b1, {(MantWidth-1){1'b0}}}
                                       : qsum[MantWidth-1:0];
        f_next.last  = p_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                p_valid_reg <= in_valid;
            end
            if (p_ready) begin
                f_valid_reg <= p_valid_reg;
            end
        end
        if (in_ready && in_valid) begin
            p_reg <= p_next;
        end
        if (p_ready && p_valid_reg) begin
            f_reg <= f_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_data  = f_reg;

endmodule
`default_nettype wire

>>> rtl/ftam_pack.sv
`default_nettype none
module ftam_pack
    import ftam_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire ftam_flt_t              in_data,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [SampleWidth-1:0]      m_tdata,
    output logic                        m_tlast
);

    logic                   valid_reg;
    logic [SampleWidth-1:0] word_reg;
    logic [SampleWidth-1:0] word_next;
    logic                   last_reg;

    logic [ShiftWidth-1:0]  neg_k;
    logic [4:0]             sh;
    logic [49:0]            shifted;
    logic [MantWidth-1:0]   ipart;
    logic                   guard;
    logic                   sticky;
    logic [MantWidth:0]     mag;
    logic                   sat;
    logic [PcmWidth-1:0]    pcm;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        neg_k   = ShiftWidth'(-in_data.shamt);
        sh      = neg_k[4:0];
        shifted = {in_data.q, 26'd0} >> sh;
        ipart   = shifted[49:26];
        guard   = shifted[25];
        sticky  = |shifted[24:0];
        mag     = {1'b0, ipart} + {{MantWidth{1'b0}}, guard && (sticky || ipart[0])};
        sat     = 1'b0;
        if (in_data.shamt > 0) begin
            sat = 1'b1;
        end else if (in_data.shamt == 0) begin
            mag = {1'b0, in_data.q};
        end else if (neg_k > ShiftWidth'(25)) begin
            mag = '0;
        end
        if (in_data.inf) begin
            sat = 1'b1;
        end
        if (!in_data.sign) begin
            if (sat || mag >= (MantWidth+1)'(24'h7FFFFF)) begin
                pcm = 24'h7FFFFF;
            end else begin
                pcm = mag[PcmWidth-1:0];
            end
        end else begin
            if (sat || mag >= (MantWidth+1)'(25'h0800000)) begin
                pcm = 24'h800000;
            end else begin
                pcm = PcmWidth'(-mag[PcmWidth-1:0]);
            end
        end
        if (in_data.nan || in_data.zero) begin
            pcm = '0;
        end
        word_next = {8'h00, pcm[7:0], pcm[15:8], pcm[23:16] | LabelByte};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            word_reg <= word_next;
            last_reg <= in_data.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

>>> rtl/float_to_am824_word_converter.sv
// channel | tdata                 | tlast
// s_      | [31:0] sample_bits    | last_sample
// m_      | [31:0] wire_word      | last_word
//
// Four register stages: unpack, scale product, float rounding, integer
// rounding and packing. One item per cycle while m_tready stays high.
// aresetn is synchronous, active low, and clears the stage valid bits.
// Each stage holds its item while the next is full and stalled.
`default_nettype none
module float_to_am824_word_converter
    import ftam_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [SampleWidth-1:0] s_tdata,   // [31:0] sample_bits
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [SampleWidth-1:0]      m_tdata,   // [31:0] wire_word
    output logic                        m_tlast
);

    logic      u_valid;
    logic      u_ready;
    ftam_unp_t u_data;
    logic      f_valid;
    logic      f_ready;
    ftam_flt_t f_data;

    ftam_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .out_valid (u_valid),
        .out_ready (u_ready),
        .out_data  (u_data)
    );

    ftam_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (u_valid),
        .in_ready  (u_ready),
        .in_data   (u_data),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    ftam_pack u_pack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  (f_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

>>> test/tb_float_to_am824_word_converter.sv
`timescale 1ns / 1ps
module tb_float_to_am824_word_converter;
    import ftam_pkg::*;

    localparam int unsigned NumRandom  = 1880;
    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned PipeDepth  = 4;

    localparam logic signed [31:0] PcmMax = 32'sd8388607;
    localparam logic signed [31:0] PcmMin = -32'sd8388608;

    typedef struct {
        logic [31:0] sample;
        logic        last;
        logic        typed;
        logic [31:0] word;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } wire_item_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SampleWidth-1:0] s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [SampleWidth-1:0] m_tdata;
    logic                   m_tlast;

    wire_item_t  pending_words[$];
    int unsigned mismatches = 0;
    int unsigned words_seen = 0;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;
    bit          stim_done = 1'b0;

    stim_row_t directed_rows[] = '{
        '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0040},
        '{32'h8000_0000, 1'b0, 1'b1, 32'h0000_0040},
        '{32'h3F80_0000, 1'b1, 1'b1, 32'h00FF_FF7F},
        '{32'hBF80_0000, 1'b0, 1'b1, 32'h0001_00C0},
        '{32'h7F80_0000, 1'b0, 1'b1, 32'h00FF_FF7F},
        '{32'hFF80_0000, 1'b1, 1'b1, 32'h0000_00C0},
        '{32'h7FC0_0000, 1'b0, 1'b1, 32'h0000_0040},
        '{32'h7F80_0001, 1'b0, 1'b1, 32'h0000_0040},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0040},
        '{32'h4000_0000, 1'b0, 1'b1, 32'h00FF_FF7F},
        '{32'hC000_0000, 1'b0, 1'b1, 32'h0000_00C0},
        '{32'h7F7F_FFFF, 1'b0, 1'b1, 32'h00FF_FF7F},
        '{32'hFF7F_FFFF, 1'b1, 1'b1, 32'h0000_00C0},
        '{32'h0000_0001, 1'b0, 1'b1, 32'h0000_0040},
        '{32'h807F_FFFF, 1'b0, 1'b1, 32'h0000_0040},
        '{32'h3F00_0000, 1'b0, 1'b0, 32'h0},
        '{32'hBF00_0000, 1'b1, 1'b0, 32'h0},
        '{32'h3F7F_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'hBF7F_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h3F80_0001, 1'b0, 1'b0, 32'h0},
        '{32'hBF80_0001, 1'b1, 1'b0, 32'h0},
        '{32'h3400_0000, 1'b0, 1'b0, 32'h0},
        '{32'h3480_0000, 1'b0, 1'b0, 32'h0},
        '{32'hB4C0_0000, 1'b0, 1'b0, 32'h0}
    };

    float_to_am824_word_converter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] sample_to_wire_word(logic [31:0] sample);
        logic [7:0]         expo;
        logic [22:0]        frac;
        logic [63:0]        prod;
        logic [63:0]        q;
        logic [63:0]        rem;
        logic [63:0]        half;
        logic [63:0]        mag;
        logic signed [31:0] pcm;
        logic [31:0]        word;
        int                 msb;
        int                 sh;
        int                 scale;
        expo = sample[30:23];
        frac = sample[22:0];
        mag = '0;
        if (expo == 8'hFF) begin
            if (frac != '0) begin
                pcm = 0;
            end else begin
                pcm = sample[31] ? PcmMin : PcmMax;
            end
        end else begin
            prod = (expo == 8'h00) ? {41'd0, frac} : {40'd0, 1'b1, frac};
            prod = prod * 64'd8388607;
            scale = (expo == 8'h00) ? -149 : int'(expo) - 150;
            if (prod != '0) begin
                msb = 0;
                for (int i = 0; i < 64; i++) begin
                    if (prod[i]) msb = i;
                end
                q = prod;
                if (msb > 23) begin
                    sh = msb - 23;
                    rem = prod & ((64'd1 << sh) - 1);
                    half = 64'd1 << (sh - 1);
                    q = prod >> sh;
                    if (rem > half || (rem == half && q[0])) q = q + 1;
                    scale = scale + sh;
                end
                if (scale >= 0) begin
                    mag = (scale > 30) ? 64'd9000000 : (q << scale);
                end else if (-scale <= 40) begin
                    rem = q & ((64'd1 << -scale) - 1);
                    half = 64'd1 << (-scale - 1);
                    mag = q >> -scale;
                    if (rem > half || (rem == half && mag[0])) mag = mag + 1;
                end
            end
            if (!sample[31]) begin
                pcm = (mag >= 64'd8388607) ? PcmMax : signed'(mag[31:0]);
            end else begin
                pcm = (mag >= 64'd8388608) ? PcmMin : -signed'(mag[31:0]);
            end
        end
        word = {pcm[23:0], 8'h00} | 32'h4000_0000;
        return {word[7:0], word[15:8], word[23:16], word[31:24]};
    endfunction

    function automatic logic [31:0] random_sample();
        logic [31:0] s;
        s = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: s[30:23] = 8'($urandom_range(96, 126));
            5: s[30:23] = 8'($urandom_range(127, 152));
            6: s = $urandom;
            7: s[30:23] = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
            8: begin
                s[30:23] = 8'($urandom_range(110, 126));
                s[22:4] = '0;
            end
            default: s[30:23] = 8'($urandom_range(0, 95));
        endcase
        return s;
    endfunction

    task automatic send_sample(logic [31:0] sample, logic last, logic typed, logic [31:0] word);
        int unsigned gap;
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
            : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_words.push_back('{typed ? word : sample_to_wire_word(sample), last});
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].sample, directed_rows[i].last,
                        directed_rows[i].typed, directed_rows[i].word);
        end
        for (int unsigned i = 0; i < NumRandom; i++) begin
            send_sample(random_sample(), 1'($urandom_range(0, 1)), 1'b0, 32'h0);
        end
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (PipeDepth + 4) @(posedge aclk);
        stim_done = 1'b1;
    end

    always @(posedge aclk) begin
        wire_item_t exp_item;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h last %b", m_tdata, m_tlast);
            end else begin
                exp_item = pending_words.pop_front();
                if (m_tdata !== exp_item.word || m_tlast !== exp_item.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected word %h last %b, got word %h last %b",
                                 exp_item.word, exp_item.last, m_tdata, m_tlast);
                    end
                end
            end
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 39) == 0) begin
            stall_left <= $urandom_range(5, 30);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0) || (cycles % 512 < 128);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (stim_done) begin
            $display("Converted %0d samples: signed zeros, full scale, saturation, infinities,",
                     words_seen);
            $display("NaNs, subnormals, rounding ties and random bit patterns under stalls.");
            if (mismatches == 0 && pending_words.size() == 0) begin
                $display("Testbench completed without errors");
            end else begin
                $display("%0d mismatches", mismatches);
                $display("Testbench completed WITH ERRORS");
            end
            $finish;
        end else if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

>>> float_to_am824_word_converter.f
rtl/ftam_pkg.sv
rtl/ftam_unpack.sv
rtl/ftam_scale.sv
rtl/ftam_pack.sv
rtl/float_to_am824_word_converter.sv
test/tb_float_to_am824_word_converter.sv
